/* sv/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg
// constants and types shared by the silhouette edge finder
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int VertexSlots    = 1024;
	localparam int EdgesPerVertex = 32;
	localparam int CoordBits      = 16;

	localparam int IdxW   = $clog2(VertexSlots);
	localparam int SlotW  = $clog2(EdgesPerVertex);
	localparam int CntW   = SlotW + 1;
	localparam int EdgeW  = IdxW + 1;
	localparam int VtxW   = 3 * CoordBits;
	localparam int TabD   = VertexSlots * EdgesPerVertex;
	localparam int DiffW  = CoordBits + 1;
	localparam int CrossW = 2 * DiffW + 1;
	localparam int ProdW  = CrossW + DiffW;
	localparam int AccW   = ProdW + 3;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_TRI   = 2'd1,
		CMD_SCAN  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LIGHT_X = 2'd0,
		REG_LIGHT_Y = 2'd1,
		REG_LIGHT_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_CLR    = 16'h0002,
		ST_T_RD   = 16'h0004,
		ST_T_DIF  = 16'h0008,
		ST_T_MUL  = 16'h0010,
		ST_E_RD   = 16'h0020,
		ST_E_WR   = 16'h0040,
		ST_S_CNT  = 16'h0080,
		ST_S_CNTW = 16'h0100,
		ST_S_ERD  = 16'h0200,
		ST_S_EGET = 16'h0400,
		ST_S_WCNT = 16'h0800,
		ST_S_RRD  = 16'h1000,
		ST_S_RGET = 16'h2000,
		ST_S_PUSH = 16'h4000,
		ST_S_FIN  = 16'h8000
	} state_t;

endpackage

/* sv/sse_ram.sv */
// ----------------------------------------------------------------------------
// sse_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sse_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/shadow_silhouette_edges.sv */
// ----------------------------------------------------------------------------
// shadow_silhouette_edges
// silhouette edge finder for stencil shadow volumes
//
// channel  | direction | content
// s_axis   | in        | tuser command, tdata indices and vertex position
// m_axis   | out       | tuser edge flag, tdata edge ends, tlast end of scan
// cfg      | in        | light position registers
//
// one item at a time; a scan reads every edge in the list of its vertex,
// and for each facing edge also walks the list of the partner vertex
// reset and clear sweep the count memory, no item taken then
// the result register lets the next item enter while a result waits;
// a scan stalls on a full result register
// ----------------------------------------------------------------------------
module shadow_silhouette_edges (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // command
	input  logic [79:0] s_tdata,   // index_a, index_b, index_c, coord_x, coord_y, coord_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [0:0]  m_tuser,   // edge_valid
	output logic        m_tlast,
	output logic [23:0] m_tdata,   // edge_start, edge_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW = sse_pkg::IdxW;
	localparam int SW = sse_pkg::SlotW;
	localparam int CW = sse_pkg::CntW;
	localparam int CB = sse_pkg::CoordBits;
	localparam int DW = sse_pkg::DiffW;

	sse_pkg::state_t state_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] a_q, b_q, c_q, w_q, pend_q;
	logic [CW-1:0] j_q, k_q, n_q, cw_q;
	logic pend_v_q, facing_q;
	logic signed [CB-1:0] lx_q, ly_q, lz_q;
	logic signed [CB-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [DW-1:0] d1x_q, d1y_q, d1z_q, d2x_q, d2y_q, d2z_q, lax_q, lay_q, laz_q;
	logic signed [sse_pkg::CrossW-1:0] nx_q, ny_q, nz_q;
	logic signed [2*DW-1:0] tmp_q;
	logic signed [sse_pkg::ProdW-1:0] prod_q;
	logic signed [sse_pkg::AccW-1:0] acc_q;
	logic signed [sse_pkg::CrossW-1:0] op_a;
	logic signed [DW-1:0] op_b;

	logic out_v_q, out_flag_q, out_last_q;
	logic [IW-1:0] out_start_q, out_end_q;
	logic out_free;

	logic vtx_we;
	logic [IW-1:0] vtx_raddr;
	logic [sse_pkg::VtxW-1:0] vtx_rdata;
	logic cnt_we;
	logic [IW-1:0] cnt_waddr, cnt_raddr;
	logic [CW-1:0] cnt_wdata, cnt_rdata;
	logic tab_we;
	logic [IW+SW-1:0] tab_waddr, tab_raddr;
	logic [sse_pkg::EdgeW-1:0] tab_wdata, tab_rdata;
	logic [IW-1:0] e_from, e_to;
	logic s_acc;

	assign s_tready  = (state_q == sse_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_v_q || m_tready;
	assign m_tvalid  = out_v_q;
	assign m_tuser   = out_flag_q;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {4'd0, out_end_q, out_start_q};

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				e_from = a_q;
				e_to   = b_q;
			end
			2'd1: begin
				e_from = b_q;
				e_to   = c_q;
			end
			default: begin
				e_from = c_q;
				e_to   = a_q;
			end
		endcase
	end

	assign vtx_we = s_acc && (s_tuser == sse_pkg::CMD_WRITE);
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    vtx_raddr = a_q;
			2'd1:    vtx_raddr = b_q;
			default: vtx_raddr = c_q;
		endcase
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = cnt_q;
		cnt_wdata = '0;
		cnt_raddr = a_q;
		tab_we    = 1'b0;
		tab_waddr = {e_from, cnt_rdata[SW-1:0]};
		tab_wdata = {facing_q, e_to};
		tab_raddr = {a_q, j_q[SW-1:0]};
		case (state_q)
			sse_pkg::ST_CLR: cnt_we = 1'b1;
			sse_pkg::ST_E_RD: cnt_raddr = e_from;
			sse_pkg::ST_E_WR: begin
				if (cnt_rdata < CW'(sse_pkg::EdgesPerVertex)) begin
					cnt_we    = 1'b1;
					cnt_waddr = e_from;
					cnt_wdata = cnt_rdata + CW'(1);
					tab_we    = 1'b1;
				end
			end
			sse_pkg::ST_S_EGET: cnt_raddr = tab_rdata[IW-1:0];
			sse_pkg::ST_S_RRD: tab_raddr = {w_q, k_q[SW-1:0]};
			default: ;
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cnt_q[3:0])
			4'd0: begin op_a = sse_pkg::CrossW'(d1y_q); op_b = d2z_q; end
			4'd1: begin op_a = sse_pkg::CrossW'(d1z_q); op_b = d2y_q; end
			4'd2: begin op_a = sse_pkg::CrossW'(d1z_q); op_b = d2x_q; end
			4'd3: begin op_a = sse_pkg::CrossW'(d1x_q); op_b = d2z_q; end
			4'd4: begin op_a = sse_pkg::CrossW'(d1x_q); op_b = d2y_q; end
			4'd5: begin op_a = sse_pkg::CrossW'(d1y_q); op_b = d2x_q; end
			4'd6: begin op_a = nx_q; op_b = lax_q; end
			4'd7: begin op_a = ny_q; op_b = lay_q; end
			4'd8: begin op_a = nz_q; op_b = laz_q; end
			default: ;
		endcase
	end

	sse_ram #(.Width(sse_pkg::VtxW), .Depth(sse_pkg::VertexSlots)) u_vtx (
		.clk(clk), .we(vtx_we), .waddr(s_tdata[IW-1:0]),
		.wdata(s_tdata[3*IW +: sse_pkg::VtxW]), .raddr(vtx_raddr), .rdata(vtx_rdata)
	);

	sse_ram #(.Width(CW), .Depth(sse_pkg::VertexSlots)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	sse_ram #(.Width(sse_pkg::EdgeW), .Depth(sse_pkg::TabD)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata)
	);

	// light registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0;
			ly_q <= '0;
			lz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sse_pkg::REG_LIGHT_X: lx_q <= cfg_data[CB-1:0];
				sse_pkg::REG_LIGHT_Y: ly_q <= cfg_data[CB-1:0];
				sse_pkg::REG_LIGHT_Z: lz_q <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (state_q)
			sse_pkg::ST_T_RD: begin
				case (cnt_q[1:0])
					2'd1: {az_q, ay_q, ax_q} <= vtx_rdata;
					2'd2: {bz_q, by_q, bx_q} <= vtx_rdata;
					2'd3: {cz_q, cy_q, cx_q} <= vtx_rdata;
					default: ;
				endcase
			end
			sse_pkg::ST_T_DIF: begin
				d1x_q <= DW'(bx_q) - DW'(ax_q);
				d1y_q <= DW'(by_q) - DW'(ay_q);
				d1z_q <= DW'(bz_q) - DW'(az_q);
				d2x_q <= DW'(cx_q) - DW'(ax_q);
				d2y_q <= DW'(cy_q) - DW'(ay_q);
				d2z_q <= DW'(cz_q) - DW'(az_q);
				lax_q <= DW'(lx_q) - DW'(ax_q);
				lay_q <= DW'(ly_q) - DW'(ay_q);
				laz_q <= DW'(lz_q) - DW'(az_q);
				acc_q <= '0;
			end
			sse_pkg::ST_T_MUL: begin
				case (cnt_q[3:0])
					4'd1, 4'd3, 4'd5: tmp_q <= prod_q[2*DW-1:0];
					4'd2: nx_q <= sse_pkg::CrossW'(tmp_q)
						- sse_pkg::CrossW'(signed'(prod_q[2*DW-1:0]));
					4'd4: ny_q <= sse_pkg::CrossW'(tmp_q)
						- sse_pkg::CrossW'(signed'(prod_q[2*DW-1:0]));
					4'd6: nz_q <= sse_pkg::CrossW'(tmp_q)
						- sse_pkg::CrossW'(signed'(prod_q[2*DW-1:0]));
					4'd7, 4'd8, 4'd9: acc_q <= acc_q + sse_pkg::AccW'(prod_q);
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sse_pkg::ST_CLR;
			cnt_q      <= '0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			w_q        <= '0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			facing_q   <= 1'b0;
			j_q        <= '0;
			k_q        <= '0;
			n_q        <= '0;
			cw_q       <= '0;
			out_v_q    <= 1'b0;
			out_flag_q <= 1'b0;
			out_last_q <= 1'b0;
			out_start_q <= '0;
			out_end_q  <= '0;
		end else begin
			if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				sse_pkg::ST_IDLE: begin
					if (s_acc) begin
						a_q   <= s_tdata[IW-1:0];
						b_q   <= s_tdata[2*IW-1:IW];
						c_q   <= s_tdata[3*IW-1:2*IW];
						cnt_q <= '0;
						case (s_tuser)
							sse_pkg::CMD_TRI:   state_q <= sse_pkg::ST_T_RD;
							sse_pkg::CMD_SCAN:  state_q <= sse_pkg::ST_S_CNT;
							sse_pkg::CMD_CLEAR: state_q <= sse_pkg::ST_CLR;
							default: ;
						endcase
					end
				end
				sse_pkg::ST_CLR: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(sse_pkg::VertexSlots - 1)) begin
						state_q <= sse_pkg::ST_IDLE;
					end
				end
				sse_pkg::ST_T_RD: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(3)) begin
						state_q <= sse_pkg::ST_T_DIF;
					end
				end
				sse_pkg::ST_T_DIF: begin
					cnt_q   <= '0;
					state_q <= sse_pkg::ST_T_MUL;
				end
				sse_pkg::ST_T_MUL: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(10)) begin
						facing_q <= !acc_q[sse_pkg::AccW-1] && (|acc_q);
						cnt_q    <= '0;
						state_q  <= sse_pkg::ST_E_RD;
					end
				end
				sse_pkg::ST_E_RD: state_q <= sse_pkg::ST_E_WR;
				sse_pkg::ST_E_WR: begin
					cnt_q <= cnt_q + IW'(1);
					state_q <= (cnt_q == IW'(2)) ? sse_pkg::ST_IDLE : sse_pkg::ST_E_RD;
				end
				sse_pkg::ST_S_CNT: state_q <= sse_pkg::ST_S_CNTW;
				sse_pkg::ST_S_CNTW: begin
					n_q     <= cnt_rdata;
					j_q     <= '0;
					state_q <= sse_pkg::ST_S_ERD;
				end
				sse_pkg::ST_S_ERD: begin
					state_q <= (j_q == n_q) ? sse_pkg::ST_S_FIN : sse_pkg::ST_S_EGET;
				end
				sse_pkg::ST_S_EGET: begin
					w_q <= tab_rdata[IW-1:0];
					if (tab_rdata[IW]) begin
						state_q <= sse_pkg::ST_S_WCNT;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= sse_pkg::ST_S_ERD;
					end
				end
				sse_pkg::ST_S_WCNT: begin
					cw_q    <= cnt_rdata;
					k_q     <= '0;
					state_q <= sse_pkg::ST_S_RRD;
				end
				sse_pkg::ST_S_RRD: begin
					state_q <= (k_q == cw_q) ? sse_pkg::ST_S_PUSH : sse_pkg::ST_S_RGET;
				end
				sse_pkg::ST_S_RGET: begin
					if (tab_rdata[IW] && (tab_rdata[IW-1:0] == a_q)) begin
						j_q     <= j_q + CW'(1);
						state_q <= sse_pkg::ST_S_ERD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= sse_pkg::ST_S_RRD;
					end
				end
				sse_pkg::ST_S_PUSH: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q     <= 1'b1;
							out_start_q <= a_q;
							out_end_q   <= pend_q;
							out_flag_q  <= 1'b1;
							out_last_q  <= 1'b0;
						end
						pend_q   <= w_q;
						pend_v_q <= 1'b1;
						j_q      <= j_q + CW'(1);
						state_q  <= sse_pkg::ST_S_ERD;
					end
				end
				sse_pkg::ST_S_FIN: begin
					if (out_free) begin
						out_v_q     <= 1'b1;
						out_start_q <= a_q;
						out_end_q   <= pend_v_q ? pend_q : '0;
						out_flag_q  <= pend_v_q;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= sse_pkg::ST_IDLE;
					end
				end
				default: state_q <= sse_pkg::ST_IDLE;
			endcase
		end
	end

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("empty result without end of scan");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("held edge left over after scan");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::ST_S_CNTW) |-> (cnt_rdata <= CW'(sse_pkg::EdgesPerVertex)))
		else $error("edge count beyond list size");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::ST_S_RRD) |-> (k_q <= cw_q))
		else $error("partner walk past its count");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the silhouette edge finder
//
// Drives vertex writes, triangles, scans and clears on the input stream,
// and loads the light position between phases while the block is idle.
// A scoreboard keeps its own copy of the mesh, predicts the edges of every
// scan and checks each output transaction against the oldest prediction.
// Both streams idle at random, with one long stretch without gaps.
// ----------------------------------------------------------------------------
module tb;

	localparam int WatchLimit = 40000;
	localparam int SettleCycles = 1100;

	typedef struct {
		logic [sse_pkg::IdxW-1:0] start_v;
		logic [sse_pkg::IdxW-1:0] end_v;
		logic                     valid;
		logic                     last;
	} edge_res_t;

	class silhouette_board;
		int px[sse_pkg::VertexSlots], py[sse_pkg::VertexSlots], pz[sse_pkg::VertexSlots];
		int cnt[sse_pkg::VertexSlots];
		logic [sse_pkg::IdxW-1:0] tab_end[sse_pkg::VertexSlots][sse_pkg::EdgesPerVertex];
		bit tab_fac[sse_pkg::VertexSlots][sse_pkg::EdgesPerVertex];
		longint lx, ly, lz;
		edge_res_t pending[$];
		int errors;
		int scans, edges_seen;

		function new();
			lx = 0; ly = 0; lz = 0;
			errors = 0; scans = 0; edges_seen = 0;
			foreach (cnt[i]) cnt[i] = 0;
		endfunction

		function void set_light(sse_pkg::reg_idx_t idx, logic signed [15:0] v);
			case (idx)
				sse_pkg::REG_LIGHT_X: lx = v;
				sse_pkg::REG_LIGHT_Y: ly = v;
				default: lz = v;
			endcase
		endfunction

		function bit lit(int a, int b, int c);
			longint d1x, d1y, d1z, d2x, d2y, d2z, nx, ny, nz, d;
			d1x = px[b] - px[a]; d1y = py[b] - py[a]; d1z = pz[b] - pz[a];
			d2x = px[c] - px[a]; d2y = py[c] - py[a]; d2z = pz[c] - pz[a];
			nx = d1y * d2z - d1z * d2y;
			ny = d1z * d2x - d1x * d2z;
			nz = d1x * d2y - d1y * d2x;
			d = nx * (lx - px[a]) + ny * (ly - py[a]) + nz * (lz - pz[a]);
			return d > 0;
		endfunction

		function void link(int from, int to, bit f);
			if (cnt[from] < sse_pkg::EdgesPerVertex) begin
				tab_end[from][cnt[from]] = to[sse_pkg::IdxW-1:0];
				tab_fac[from][cnt[from]] = f;
				cnt[from]++;
			end
		endfunction

		function bit paired(int v, int w);
			for (int k = 0; k < cnt[w]; k++)
				if (tab_end[w][k] == v[sse_pkg::IdxW-1:0] && tab_fac[w][k]) return 1;
			return 0;
		endfunction

		function void note_input(sse_pkg::cmd_t cmd, logic [79:0] d);
			int a, b, c, n0;
			bit f;
			edge_res_t r;
			a = d[9:0]; b = d[19:10]; c = d[29:20];
			case (cmd)
				sse_pkg::CMD_WRITE: begin
					px[a] = $signed(d[45:30]);
					py[a] = $signed(d[61:46]);
					pz[a] = $signed(d[77:62]);
				end
				sse_pkg::CMD_TRI: begin
					f = lit(a, b, c);
					link(a, b, f);
					link(b, c, f);
					link(c, a, f);
				end
				sse_pkg::CMD_CLEAR: foreach (cnt[i]) cnt[i] = 0;
				default: begin
					scans++;
					n0 = pending.size();
					for (int j = 0; j < cnt[a]; j++) begin
						if (tab_fac[a][j] && !paired(a, tab_end[a][j])) begin
							r.start_v = a[sse_pkg::IdxW-1:0]; r.end_v = tab_end[a][j];
							r.valid = 1'b1; r.last = 1'b0;
							pending.push_back(r);
						end
					end
					if (pending.size() == n0) begin
						r.start_v = a[sse_pkg::IdxW-1:0]; r.end_v = '0;
						r.valid = 1'b0; r.last = 1'b1;
						pending.push_back(r);
					end else begin
						pending[pending.size()-1].last = 1'b1;
					end
				end
			endcase
		endfunction

		function void check(logic [23:0] data, logic user, logic lst);
			edge_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction data=%h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.valid) edges_seen++;
			if (data[9:0] !== e.start_v) begin
				$error("edge_start expected %0d actual %0d", e.start_v, data[9:0]);
				errors++;
			end
			if (data[19:10] !== e.end_v) begin
				$error("edge_end expected %0d actual %0d", e.end_v, data[19:10]);
				errors++;
			end
			if (user !== e.valid) begin
				$error("edge_valid expected %0d actual %0d", e.valid, user);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last expected %0d actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [1:0]  s_tuser = sse_pkg::CMD_WRITE;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic [23:0] m_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = sse_pkg::REG_LIGHT_X;
	logic [15:0] cfg_data = '0;

	silhouette_board board = new();
	bit calm = 0;
	int quiet = 0;
	int pool[8];

	shadow_silhouette_edges dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function bit gap();
		return !calm && $urandom_range(99) < 28;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check(m_tdata, m_tuser[0], m_tlast);
		m_tready <= !gap();
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WatchLimit) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send(sse_pkg::cmd_t cmd, int a, int b, int c, int x, int y, int z);
		logic [79:0] dat;
		dat = {2'b00, z[15:0], y[15:0], x[15:0], c[9:0], b[9:0], a[9:0]};
		if (gap()) begin
			s_tvalid <= 0;
			do @(posedge clk); while (gap());
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= dat;
		do @(posedge clk); while (!s_tready);
		board.note_input(cmd, dat);
	endtask

	task automatic put_vertex(int a, int x, int y, int z);
		send(sse_pkg::CMD_WRITE, a, $urandom, $urandom, x, y, z);
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_light(int x, int y, int z);
		int v[3];
		v = '{x, y, z};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1;
			cfg_index <= sse_pkg::reg_idx_t'(i);
			cfg_data <= v[i][15:0];
			do @(posedge clk); while (!cfg_ready);
			board.set_light(sse_pkg::reg_idx_t'(i), v[i][15:0]);
		end
		cfg_valid <= 0;
	endtask

	function automatic int rcoord();
		case ($urandom_range(9))
			0: return 32'h8000;
			1: return 32'h7fff;
			2, 3: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int p, a, b, c;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (SettleCycles) @(posedge clk);

		// directed: extremes, facing and back-facing, degenerate, full list
		set_light(16'h7fff, 16'h8000, 16'h7fff);
		put_vertex(0, 16'h8000, 16'h8000, 16'h8000);
		put_vertex(1023, 16'h7fff, 16'h8000, 16'h8000);
		put_vertex(682, 16'h8000, 16'h7fff, 16'h7fff);
		put_vertex(341, 16'h0, 16'h0, 16'h0);
		send(sse_pkg::CMD_SCAN, 341, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_TRI, 0, 1023, 682, 0, 0, 0);
		send(sse_pkg::CMD_TRI, 0, 682, 1023, 0, 0, 0);
		send(sse_pkg::CMD_TRI, 341, 341, 341, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 1023, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 341, 0, 0, 0, 0, 0);
		for (int i = 0; i < 40; i++) send(sse_pkg::CMD_TRI, 1023, 0, 341, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 1023, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send(sse_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			calm = (ph == 3);
			if (ph == 1) set_light(16'h8000, 16'h7fff, 16'h8000);
			else if (ph == 2) set_light(0, 0, 0);
			else set_light(rcoord(), rcoord(), rcoord());
			send(sse_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			for (int i = 0; i < 8; i++) begin
				pool[i] = $urandom_range(1023);
				put_vertex(pool[i], rcoord(), rcoord(), rcoord());
			end
			for (int i = 0; i < 30; i++) begin
				p = $urandom_range(99);
				if (p < 48) begin
					a = pool[$urandom_range(7)];
					b = pool[$urandom_range(7)];
					c = pool[$urandom_range(7)];
					send(sse_pkg::CMD_TRI, a, b, c, $urandom, $urandom, $urandom);
				end else if (p < 80) begin
					a = ($urandom_range(9) == 0) ? $urandom_range(1023) : pool[$urandom_range(7)];
					send(sse_pkg::CMD_SCAN, a, $urandom, $urandom, $urandom, $urandom,
						$urandom);
				end else if (p < 90) begin
					put_vertex(pool[$urandom_range(7)], rcoord(), rcoord(), rcoord());
				end else if (p < 94) begin
					send(sse_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				end else begin
					put_vertex($urandom_range(1023), rcoord(), rcoord(), rcoord());
				end
			end
			settle();
		end

		$display("tb: %0d scans checked, %0d silhouette edges seen, 8 light settings",
			board.scans, board.edges_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

/* filelist.f */
sv/sse_pkg.sv
sv/sse_ram.sv
sv/shadow_silhouette_edges.sv
dv/tb.sv
